>>> rtl/core/rau_pkg.sv
package rau_pkg;

  localparam int OPW = 16;           // operand field width
  localparam int MW  = 2 * OPW + 1;  // internal magnitude width
  localparam int NUMW = 33;
  localparam int DENW = 31;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BADEN = 2'd1;
  localparam logic [1:0] ST_DIVZ  = 2'd2;

  // datapath commands from the controller
  typedef enum logic [3:0] {
    CMD_IDLE  = 4'd0,
    CMD_LOAD  = 4'd1,  // capture operands, split signs
    CMD_RED_A = 4'd2,  // start reduction of left operand
    CMD_RED_B = 4'd3,  // start reduction of right operand
    CMD_CROSS = 4'd4,  // form cross products
    CMD_COMB  = 4'd5,  // add, subtract, multiply or divide, load result reduction
    CMD_GSTEP = 4'd6,  // advance the gcd modulo step: load, one remainder bit, or swap
    CMD_DIVQ  = 4'd7,  // start quotient divides
    CMD_DSTEP = 4'd8,  // one restoring divide bit
    CMD_STA   = 4'd9,  // store reduced left operand
    CMD_STB   = 4'd10, // store reduced right operand
    CMD_STR   = 4'd11  // store result to output register
  } cmd_t;

  typedef struct packed {
    logic gcd_done;    // remainder operand is zero
    logic div_done;    // quotient divide finished
    logic den_zero;    // an operand denominator is zero
    logic div_zero;    // divide by zero fraction
    logic red_zero;    // numerator or denominator of reduction is zero
  } stat_t;

endpackage

>>> rtl/core/rau_datapath.sv
module rau_datapath (
  input  logic                              clk,
  input  rau_pkg::cmd_t                     cmd,
  input  logic [1:0]                        opcode,
  input  logic signed [rau_pkg::OPW-1:0]    lhs_num,
  input  logic signed [rau_pkg::OPW-1:0]    lhs_den,
  input  logic signed [rau_pkg::OPW-1:0]    rhs_num,
  input  logic signed [rau_pkg::OPW-1:0]    rhs_den,
  input  logic [1:0]                        st_code,
  output rau_pkg::stat_t                    stat,
  output logic signed [rau_pkg::NUMW-1:0]   res_num,
  output logic [rau_pkg::DENW-1:0]          res_den,
  output logic [1:0]                        status
);

  localparam int OPW  = rau_pkg::OPW;
  localparam int MW   = rau_pkg::MW;
  localparam int NUMW = rau_pkg::NUMW;
  localparam int DENW = rau_pkg::DENW;
  localparam int CW   = $clog2(MW + 1);

  logic [1:0]    op;
  logic          ln_s, ld_s, rn_s, rd_s;
  logic [MW-1:0] an, ad, bn, bd;
  logic          a_neg, b_neg;
  logic [MW-1:0] rn, rd;        // reduction operands
  logic          r_neg;
  logic [MW-1:0] ga, gb;        // gcd pair
  logic [MW-1:0] mrem;          // modulo remainder in progress
  logic [MW-1:0] dq_n, dq_d;    // quotients
  logic [MW-1:0] drem_n, drem_d;
  logic [CW-1:0] cnt;
  logic          mod_busy;
  logic [MW-1:0] x, y;

  function automatic logic [MW-1:0] mag(input logic [OPW-1:0] v);
    logic [OPW-1:0] m;
    m = v[OPW-1] ? (~v + OPW'(1)) : v;
    return MW'(m);
  endfunction

  // restoring divide bit: rem,q shift in a bit of q
  logic [MW:0] tn, td, tm;
  assign tn = {drem_n, dq_n[MW-1]};
  assign td = {drem_d, dq_d[MW-1]};
  // modulo by shift-subtract over bits of mrem source
  assign tm = {mrem, dq_n[MW-1]};

  always_ff @(posedge clk) begin
    unique case (cmd)
      rau_pkg::CMD_LOAD: begin
        op <= opcode;
        ln_s <= lhs_num[OPW-1]; ld_s <= lhs_den[OPW-1];
        rn_s <= rhs_num[OPW-1]; rd_s <= rhs_den[OPW-1];
        an <= mag(lhs_num); ad <= mag(lhs_den);
        bn <= mag(rhs_num); bd <= mag(rhs_den);
      end
      rau_pkg::CMD_RED_A: begin
        rn <= an; rd <= ad; r_neg <= ln_s ^ ld_s;
        ga <= an; gb <= ad; mod_busy <= 1'b0;
      end
      rau_pkg::CMD_RED_B: begin
        rn <= bn; rd <= bd; r_neg <= rn_s ^ rd_s;
        ga <= bn; gb <= bd; mod_busy <= 1'b0;
      end
      rau_pkg::CMD_CROSS: begin
        x <= MW'(an * (op == rau_pkg::OP_DIV ? bd : bd));
        y <= MW'(bn * ad);
      end
      rau_pkg::CMD_COMB: begin
        mod_busy <= 1'b0;
        if (op == rau_pkg::OP_MUL) begin
          rn <= MW'(an * bn); r_neg <= a_neg ^ b_neg;
          rd <= MW'(ad * bd);
          ga <= MW'(an * bn); gb <= MW'(ad * bd);
        end else if (op == rau_pkg::OP_DIV) begin
          rn <= x; rd <= y; r_neg <= a_neg ^ b_neg;
          ga <= x; gb <= y;
        end else begin
          rd <= MW'(ad * bd); gb <= MW'(ad * bd);
          if (a_neg == (b_neg ^ (op == rau_pkg::OP_SUB))) begin
            rn <= x + y; ga <= x + y; r_neg <= a_neg;
          end else if (x >= y) begin
            rn <= x - y; ga <= x - y; r_neg <= a_neg;
          end else begin
            rn <= y - x; ga <= y - x; r_neg <= b_neg ^ (op == rau_pkg::OP_SUB);
          end
        end
      end
      rau_pkg::CMD_GSTEP: begin
        // ga mod gb, one bit per cycle; dq_n holds dividend bits
        if (!mod_busy) begin
          mod_busy <= 1'b1;
          mrem <= '0; dq_n <= ga; cnt <= CW'(MW);
        end else if (cnt != '0) begin
          cnt <= cnt - CW'(1);
          dq_n <= dq_n << 1;
          mrem <= (tm >= {1'b0, gb}) ? MW'(tm - {1'b0, gb}) : MW'(tm);
        end else begin
          ga <= gb; gb <= mrem; mod_busy <= 1'b0;
        end
      end
      rau_pkg::CMD_DIVQ: begin
        dq_n <= rn; dq_d <= rd; drem_n <= '0; drem_d <= '0;
        cnt <= CW'(MW);
      end
      rau_pkg::CMD_DSTEP: begin
        cnt <= cnt - CW'(1);
        dq_n <= {dq_n[MW-2:0], tn >= {1'b0, ga}};
        dq_d <= {dq_d[MW-2:0], td >= {1'b0, ga}};
        drem_n <= (tn >= {1'b0, ga}) ? MW'(tn - {1'b0, ga}) : MW'(tn);
        drem_d <= (td >= {1'b0, ga}) ? MW'(td - {1'b0, ga}) : MW'(td);
      end
      rau_pkg::CMD_STA: begin
        an <= stat.red_zero ? '0 : dq_n;
        ad <= stat.red_zero ? MW'(1) : dq_d;
        a_neg <= stat.red_zero ? 1'b0 : r_neg;
      end
      rau_pkg::CMD_STB: begin
        bn <= stat.red_zero ? '0 : dq_n;
        bd <= stat.red_zero ? MW'(1) : dq_d;
        b_neg <= stat.red_zero ? 1'b0 : r_neg;
      end
      rau_pkg::CMD_STR: begin
        status <= st_code;
        if (st_code != rau_pkg::ST_OK || stat.red_zero) begin
          res_num <= '0; res_den <= DENW'(1);
        end else begin
          res_num <= r_neg ? -$signed(NUMW'(dq_n)) : $signed(NUMW'(dq_n));
          res_den <= DENW'(dq_d);
        end
      end
      default: ;
    endcase
  end

  assign stat.gcd_done = (gb == '0);
  assign stat.div_done = (cnt == '0);
  assign stat.den_zero = (ad == '0) || (bd == '0);
  assign stat.div_zero = (op == rau_pkg::OP_DIV) && (bn == '0);
  assign stat.red_zero = (rn == '0) || (rd == '0);

endmodule

>>> rtl/core/rau_ctrl.sv
module rau_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  rau_pkg::stat_t stat,
  output rau_pkg::cmd_t  cmd,
  output logic [1:0]     st_code
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CHK   = 10'b0000000010,
    S_START = 10'b0000000100,
    S_GCD   = 10'b0000001000,
    S_DINI  = 10'b0000010000,
    S_DIV   = 10'b0000100000,
    S_STORE = 10'b0001000000,
    S_CROSS = 10'b0010000000,
    S_COMB  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t     state, state_next;
  logic [1:0] phase, phase_next;   // 0 left, 1 right, 2 result
  logic [1:0] code, code_next;
  logic       ovalid, ovalid_next;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = ovalid;
  assign st_code   = code;

  always_comb begin
    state_next = state; phase_next = phase; code_next = code;
    ovalid_next = ovalid && out_stall;
    cmd = rau_pkg::CMD_IDLE;
    unique case (state)
      S_IDLE: if (in_valid) begin
        cmd = rau_pkg::CMD_LOAD; state_next = S_CHK;
      end
      S_CHK: begin
        phase_next = 2'd0;
        if (stat.den_zero) begin
          code_next = rau_pkg::ST_BADEN; state_next = S_OUT;
        end else begin
          code_next = rau_pkg::ST_OK;
          cmd = rau_pkg::CMD_RED_A; state_next = S_GCD;
        end
      end
      S_START: begin
        cmd = rau_pkg::CMD_RED_B; state_next = S_GCD;
      end
      S_GCD: begin
        if (stat.gcd_done || stat.red_zero) state_next = S_DINI;
        else cmd = rau_pkg::CMD_GSTEP;
      end
      S_DINI: begin cmd = rau_pkg::CMD_DIVQ; state_next = S_DIV; end
      S_DIV: begin
        if (stat.div_done) state_next = S_STORE;
        else cmd = rau_pkg::CMD_DSTEP;
      end
      S_STORE: begin
        if (phase == 2'd0) begin
          cmd = rau_pkg::CMD_STA; phase_next = 2'd1; state_next = S_START;
        end else if (phase == 2'd1) begin
          cmd = rau_pkg::CMD_STB; phase_next = 2'd2; state_next = S_CROSS;
        end else begin
          state_next = S_OUT;
        end
      end
      S_CROSS: begin
        if (stat.div_zero) begin
          code_next = rau_pkg::ST_DIVZ; state_next = S_OUT;
        end else begin
          cmd = rau_pkg::CMD_CROSS; state_next = S_COMB;
        end
      end
      S_COMB: begin cmd = rau_pkg::CMD_COMB; state_next = S_GCD; end
      S_OUT: if (!ovalid) begin
        cmd = rau_pkg::CMD_STR; ovalid_next = 1'b1; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; phase <= 2'd0; code <= rau_pkg::ST_OK; ovalid <= 1'b0;
    end else begin
      state <= state_next; phase <= phase_next; code <= code_next;
      ovalid <= ovalid_next;
    end
  end

`ifndef ASSERT_OFF
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    ovalid && out_stall |=> ovalid) else $error("result dropped");
  a_str: assert property (@(posedge clk) disable iff (rst)
    cmd == rau_pkg::CMD_STR |-> !ovalid) else $error("result overwritten");
`endif

endmodule

>>> rtl/core/rational_arithmetic_unit_core.sv
// channel | handshake             | payload
// in      | in_valid / in_stall   | opcode lhs_num lhs_den rhs_num rhs_den
// out     | out_valid / out_stall | res_num res_den status
// one item at a time; a transfer in starts up to three gcd reductions
// each gcd step is a shift-subtract modulo (load, dividend bits MSB first, swap), each
// reduction ends with a quotient divide, and a zero denominator skips all reductions
// the result register lets the core finish while out is stalled
// rst is synchronous and active high and clears the controller only
module rational_arithmetic_unit_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      opcode,
  input  logic signed [rau_pkg::OPW-1:0]  lhs_num,
  input  logic signed [rau_pkg::OPW-1:0]  lhs_den,
  input  logic signed [rau_pkg::OPW-1:0]  rhs_num,
  input  logic signed [rau_pkg::OPW-1:0]  rhs_den,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [rau_pkg::NUMW-1:0] res_num,
  output logic [rau_pkg::DENW-1:0]        res_den,
  output logic [1:0]                      status
);

  rau_pkg::cmd_t  cmd;
  rau_pkg::stat_t stat;
  logic [1:0]     st_code;

  // sequencer
  rau_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .stat, .cmd, .st_code
  );

  // operand registers, gcd and divide units, result register
  rau_datapath u_dp (
    .clk, .cmd, .opcode, .lhs_num, .lhs_den, .rhs_num, .rhs_den,
    .st_code, .stat, .res_num, .res_den, .status
  );

endmodule

>>> test/tb_rational_arithmetic_unit_core.sv
`timescale 1ns / 100ps

module tb_rational_arithmetic_unit_core;

  // cycles an item may take in the worst case, several times over
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int DRAIN_CYCLES   = 2000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         opcode;
  logic signed [15:0] lhs_num;
  logic signed [15:0] lhs_den;
  logic signed [15:0] rhs_num;
  logic signed [15:0] rhs_den;
  logic               out_valid;
  logic               out_stall;
  logic signed [32:0] res_num;
  logic [30:0]        res_den;
  logic [1:0]         status;

  typedef struct {
    logic signed [32:0] num;
    logic [30:0]        den;
    logic [1:0]         st;
  } quotient_t;

  quotient_t expected_quotients[$];

  int mismatches;
  int items_sent;
  int results_seen;
  int idle_cycles;
  bit sink_idle_en;
  bit source_idle_en;
  bit sink_hold;
  bit timed_out;

  rational_arithmetic_unit_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .lhs_num(lhs_num), .lhs_den(lhs_den),
    .rhs_num(rhs_num), .rhs_den(rhs_den),
    .out_valid(out_valid), .out_stall(out_stall),
    .res_num(res_num), .res_den(res_den), .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned euclid(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // bring a signed magnitude fraction to lowest terms, zero becomes 0/1
  function automatic void lowest_terms(input bit neg, input longint unsigned n,
                                       input longint unsigned d, output bit rneg,
                                       output longint unsigned rn,
                                       output longint unsigned rd);
    longint unsigned g;
    if (n == 0 || d == 0) begin
      rneg = 1'b0;
      rn = 0;
      rd = 1;
    end else begin
      g = euclid(n, d);
      rneg = neg;
      rn = n / g;
      rd = d / g;
    end
  endfunction

  function automatic longint unsigned magnitude(logic signed [15:0] v);
    return (v < 0) ? longint'(-int'(v)) : longint'(v);
  endfunction

  // expected reduced fraction and status for one operation
  function automatic quotient_t rational_result(logic [1:0] op, logic signed [15:0] an,
                                                logic signed [15:0] ad,
                                                logic signed [15:0] bn,
                                                logic signed [15:0] bd);
    quotient_t q;
    bit aneg, bneg, xneg, yneg, sneg, rneg;
    longint unsigned a_n, a_d, b_n, b_d, x, y, s, rn, rd;
    q.num = '0;
    q.den = 31'd1;
    q.st = rau_pkg::ST_OK;
    if (ad == 0 || bd == 0) begin
      q.st = rau_pkg::ST_BADEN;
      return q;
    end
    lowest_terms((an < 0) != (ad < 0), magnitude(an), magnitude(ad), aneg, a_n, a_d);
    lowest_terms((bn < 0) != (bd < 0), magnitude(bn), magnitude(bd), bneg, b_n, b_d);
    case (op) inside
      rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
        x = a_n * b_d;
        y = b_n * a_d;
        xneg = aneg;
        yneg = (op == rau_pkg::OP_SUB) ? !bneg : bneg;
        if (xneg == yneg) begin
          s = x + y;
          sneg = xneg;
        end else if (x >= y) begin
          s = x - y;
          sneg = xneg;
        end else begin
          s = y - x;
          sneg = yneg;
        end
        lowest_terms(sneg, s, a_d * b_d, rneg, rn, rd);
      end
      rau_pkg::OP_MUL: lowest_terms(aneg != bneg, a_n * b_n, a_d * b_d, rneg, rn, rd);
      default: begin
        if (b_n == 0) begin
          q.st = rau_pkg::ST_DIVZ;
          return q;
        end
        lowest_terms(aneg != bneg, a_n * b_d, a_d * b_n, rneg, rn, rd);
      end
    endcase
    q.num = rneg ? -$signed({1'b0, rn[31:0]}) : $signed({1'b0, rn[31:0]});
    q.den = rd[30:0];
    return q;
  endfunction

  // offer one item until it transfers, with random idle cycles before it while source idling is enabled
  task automatic send_fraction_pair(input logic [1:0] op, input logic signed [15:0] an,
                                    input logic signed [15:0] ad,
                                    input logic signed [15:0] bn,
                                    input logic signed [15:0] bd);
    do @(negedge clk); while (source_idle_en && $urandom_range(99) < 26);
    in_valid <= 1'b1;
    opcode   <= op;
    lhs_num  <= an;
    lhs_den  <= ad;
    rhs_num  <= bn;
    rhs_den  <= bd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_quotients.push_back(rational_result(op, an, ad, bn, bd));
    items_sent++;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_quotients.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [15:0] random_operand();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return $signed(16'($urandom_range(9)) - 16'sd4);
      3: return $signed(16'($urandom_range(400)) - 16'sd200);
      default: return $signed(16'($urandom));
    endcase
  endfunction

  // extremes, every operation and each error case
  task automatic test_directed();
    logic [1:0] op;
    for (int k = 0; k < 4; k++) begin
      op = 2'(k);
      send_fraction_pair(op, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
      send_fraction_pair(op, -16'sd3, 16'sd6, 16'sd5, -16'sd10);
      send_fraction_pair(op, 16'sd0, -16'sd7, 16'sh8000, 16'sh8000);
      send_fraction_pair(op, 16'sd1, 16'sd0, 16'sd1, 16'sd1);
    end
    // zero denominator wins over division by zero
    send_fraction_pair(rau_pkg::OP_DIV, 16'sd1, 16'sd2, 16'sd0, 16'sd0);
    send_fraction_pair(rau_pkg::OP_DIV, 16'sd1, 16'sd2, 16'sd0, 16'sd5);
    send_fraction_pair(rau_pkg::OP_SUB, 16'sd4, 16'sd9, 16'sd4, 16'sd9);
    send_fraction_pair(rau_pkg::OP_ADD, 16'sd4, 16'sd9, -16'sd4, 16'sd9);
    send_fraction_pair(rau_pkg::OP_MUL, 16'sh8000, 16'sd1, 16'sh8000, 16'sd1);
    send_fraction_pair(rau_pkg::OP_DIV, 16'sh8000, 16'sd1, 16'sd1, 16'sh7fff);
    send_fraction_pair(rau_pkg::OP_ADD, 16'shffff, 16'shffff, 16'shffff, 16'sh7ffe);
    wait_drained();
  endtask

  // random operands, mostly legal, occasional zero denominators
  task automatic test_random(input int count);
    logic signed [15:0] ad, bd;
    for (int k = 0; k < count; k++) begin
      ad = random_operand();
      bd = random_operand();
      if (ad == 0 && $urandom_range(3) != 0) ad = 16'sd1;
      if (bd == 0 && $urandom_range(3) != 0) bd = -16'sd1;
      send_fraction_pair(2'($urandom), random_operand(), ad, random_operand(), bd);
    end
  endtask

  // long sink hold-off while items keep arriving, so in_stall must rise
  task automatic test_backpressure();
    sink_hold = 1'b1;
    fork
      test_random(6);
      begin
        repeat (3000) @(negedge clk);
        sink_hold = 1'b0;
      end
    join
    wait_drained();
  endtask

  // no idling on either side
  task automatic test_full_rate();
    sink_idle_en = 1'b0;
    source_idle_en = 1'b0;
    test_random(80);
    wait_drained();
    sink_idle_en = 1'b1;
    source_idle_en = 1'b1;
  endtask

  // sink stall, random while sink idling is enabled, held high while a hold-off is running
  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= sink_hold || (sink_idle_en && $urandom_range(99) < 26);
  end

  // compare every result transfer with the oldest expectation
  always @(posedge clk) begin
    quotient_t q;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_quotients.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d/%0d status %0d",
                                       res_num, res_den, status);
      end else begin
        q = expected_quotients.pop_front();
        if (res_num !== q.num || res_den !== q.den || status !== q.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d/%0d status %0d, got %0d/%0d status %0d",
                     q.num, q.den, q.st, res_num, res_den, status);
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    timed_out = 1'b1;
    $display("watchdog expired with %0d results outstanding", expected_quotients.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    opcode = rau_pkg::OP_ADD;
    lhs_num = '0;
    lhs_den = 16'sd1;
    rhs_num = '0;
    rhs_den = 16'sd1;
    mismatches = 0;
    items_sent = 0;
    results_seen = 0;
    idle_cycles = 0;
    sink_idle_en = 1'b1;
    source_idle_en = 1'b1;
    sink_hold = 1'b0;
    timed_out = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_backpressure();
    test_full_rate();
    test_random(440);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("sent %0d fraction pairs over all four operations and both error cases,",
             items_sent);
    $display("checked %0d results with random idling and a long output hold-off",
             results_seen);
    if (mismatches == 0 && expected_quotients.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_quotients.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> rational_arithmetic_unit_core.f
rtl/core/rau_pkg.sv
rtl/core/rau_datapath.sv
rtl/core/rau_ctrl.sv
rtl/core/rational_arithmetic_unit_core.sv
test/tb_rational_arithmetic_unit_core.sv
